/* hw/rtl/tlvp_pkg.sv */
package tlvp_pkg;

	localparam int MaxRecord = 2048;
	localparam int HdrLen = 11;
	localparam logic [10:0] MaxLen = 11'((MaxRecord - HdrLen) > 2047 ? 2047 : (MaxRecord - HdrLen));

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_SIGNATURE = 4'd2;
	localparam logic [3:0] ST_VERSION   = 4'd3;
	localparam logic [3:0] ST_LENGTH    = 4'd4;
	localparam logic [3:0] ST_NO_CRC    = 4'd5;
	localparam logic [3:0] ST_CRC_BAD   = 4'd6;
	localparam logic [3:0] ST_RESERVED  = 4'd7;
	localparam logic [3:0] ST_TRUNC     = 4'd8;

	localparam logic [7:0] TYPE_MAC   = 8'h24;
	localparam logic [7:0] TYPE_COUNT = 8'h26;
	localparam logic [7:0] TYPE_VID   = 8'h2A;
	localparam logic [7:0] TYPE_CRC   = 8'hFE;
	localparam logic [7:0] TYPE_VEND  = 8'hFD;
	localparam logic [7:0] TYPE_STR_LO = 8'h21;
	localparam logic [7:0] TYPE_STR_HI = 8'h2E;
	localparam logic [7:0] TYPE_RSV_LO = 8'h00;
	localparam logic [7:0] TYPE_RSV_HI = 8'hFF;

	typedef enum logic [3:0] {
		PH_TYPE  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_HALT  = 4'b1000
	} phase_t;

	// one classified byte handed from front to back
	typedef struct packed {
		logic        emit;
		logic [7:0]  etype;
		logic [7:0]  vidx;
		logic [7:0]  vbyte;
		logic        done;
		logic [10:0] dlen;
		logic        fin;
		logic [3:0]  status;
	} work_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [7:0]  etype;
		logic [7:0]  vidx;
		logic [7:0]  vbyte;
		logic        done;
		logic [3:0]  status;
		logic [10:0] dlen;
		logic        last;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] type_cap(input logic [7:0] t);
		logic [7:0] r;
		case (t)
			TYPE_MAC:   r = 8'd6;
			TYPE_COUNT: r = 8'd1;
			TYPE_VID:   r = 8'd2;
			TYPE_CRC:   r = 8'd4;
			default:    r = (t >= TYPE_STR_LO && t <= TYPE_STR_HI) ? 8'd255 : 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sig_byte(input logic [2:0] p);
		logic [7:0] r;
		case (p)
			3'd0: r = 8'h54;
			3'd1: r = 8'h6C;
			3'd2: r = 8'h76;
			3'd3: r = 8'h49;
			3'd4: r = 8'h6E;
			3'd5: r = 8'h66;
			3'd6: r = 8'h6F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/tlv_eeprom_record_parser_core.sv */
// record parser: push one eeprom byte per cycle while full is low, up to one
// request per cycle sustained; the front classifies a byte and registers the
// byte-wide crc-32 and parse state; a four-entry queue feeds the outputs.
// a result shows on the outputs once it is at the head of the queue; bytes
// that give no result never enter the queue. a value byte gives one result,
// the final byte gives its value result (if any) and then the status, so a
// last byte costs one or two pops. full rises only while four entries wait.
// value results are speculative: discard them when the status is not zero.
module tlv_eeprom_record_parser_core import tlvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  entry_type,
	output logic [7:0]  value_index,
	output logic [7:0]  value_out,
	output logic        entry_done,
	output logic [3:0]  status,
	output logic [10:0] declared_length,
	output logic        last
);

	work_t   work;
	result_t res;
	logic    go;

	// accepted request
	assign go = push && !full;

	tlvp_front u_front (
		.clk, .arst_n, .in_go(go), .data_byte, .last_byte, .work
	);

	tlvp_back u_back (
		.clk, .arst_n, .wr(go), .wdata(work), .full, .empty, .pop, .res
	);

	assign kind = res.kind;
	assign entry_type = res.etype;
	assign value_index = res.vidx;
	assign value_out = res.vbyte;
	assign entry_done = res.done;
	assign status = res.status;
	assign declared_length = res.dlen;
	assign last = res.last;

endmodule

/* hw/rtl/tlvp_front.sv */
module tlvp_front import tlvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_go,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output work_t      work
);

	logic [11:0] pos_q;
	logic [10:0] tlen_q;
	logic        hgood_q;
	phase_t      phase_q;
	logic [7:0]  ctype_q;
	logic [7:0]  rem_q;
	logic [7:0]  vcnt_q;
	logic [31:0] crc_q;
	logic [31:0] scrc_q;
	logic        crcok_q;
	logic [3:0]  ferr_q;

	logic [11:0] pos_n;
	logic [10:0] tlen_n;
	logic        hgood_n;
	phase_t      phase_n;
	logic [7:0]  ctype_n;
	logic [7:0]  rem_n;
	logic [7:0]  vcnt_n;
	logic [31:0] crc_n;
	logic [31:0] scrc_n;
	logic        crcok_n;
	logic [3:0]  ferr_n;
	logic [11:0] rec_end;
	logic [11:0] full_len;
	logic [8:0]  vlen;
	logic [7:0]  cap;
	logic [8:0]  lim;
	logic [12:0] cnt;
	logic [3:0]  st;

	always_comb begin
		pos_n = pos_q; tlen_n = tlen_q; hgood_n = hgood_q; phase_n = phase_q;
		ctype_n = ctype_q; rem_n = rem_q; vcnt_n = vcnt_q; crc_n = crc_q;
		scrc_n = scrc_q; crcok_n = crcok_q; ferr_n = ferr_q;
		rec_end = 12'(HdrLen) + {1'b0, tlen_q};
		full_len = {tlen_q[3:0], data_byte};
		vlen = {1'b0, vcnt_q} + {1'b0, rem_q};
		cap = type_cap(ctype_q);
		lim = (vlen < {1'b0, cap}) ? vlen : {1'b0, cap};
		work = '0;
		if (pos_q < 12'(HdrLen)) begin
			crc_n = crc_byte(crc_q, data_byte);
			if (pos_q < 12'd8) begin
				if (data_byte != sig_byte(pos_q[2:0])) begin
					if (hgood_q) ferr_n = ST_SIGNATURE;
					hgood_n = 1'b0;
				end
			end else if (pos_q == 12'd8) begin
				if (data_byte != 8'd1) begin
					if (hgood_q) ferr_n = ST_VERSION;
					hgood_n = 1'b0;
				end
			end else if (pos_q == 12'd9) begin
				tlen_n = {3'd0, data_byte};
			end else begin
				full_len = {tlen_q[3:0], data_byte};
				if ({tlen_q[7:0], data_byte} > {5'd0, MaxLen}) begin
					if (hgood_q) ferr_n = ST_LENGTH;
					hgood_n = 1'b0;
					tlen_n = (tlen_q[7:3] != 5'd0) ? 11'd2047 : full_len[10:0];
				end else begin
					tlen_n = full_len[10:0];
				end
			end
		end else if (hgood_q && pos_q < rec_end) begin
			if (pos_q + 12'd4 < rec_end) crc_n = crc_byte(crc_q, data_byte);
			else scrc_n = {scrc_q[23:0], data_byte};
			if (tlen_q >= 11'd6) begin
				if (pos_q == rec_end - 12'd6) crcok_n = (data_byte == TYPE_CRC);
				if (pos_q == rec_end - 12'd5) crcok_n = crcok_q && (data_byte == 8'd4);
			end
			case (phase_q)
				PH_TYPE: begin
					if (data_byte == TYPE_RSV_LO || data_byte == TYPE_RSV_HI) begin
						if (ferr_q == ST_OK) ferr_n = ST_RESERVED;
						phase_n = PH_HALT;
					end else begin
						ctype_n = data_byte;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					rem_n = data_byte;
					vcnt_n = '0;
					phase_n = (data_byte != 8'd0) ? PH_VALUE : PH_TYPE;
				end
				PH_VALUE: begin
					if ({1'b0, vcnt_q} < lim) begin
						work.emit = 1'b1;
						work.etype = ctype_q;
						work.vidx = vcnt_q;
						work.vbyte = data_byte;
						work.done = ({1'b0, vcnt_q} + 9'd1 == lim);
					end
					vcnt_n = vcnt_q + 8'd1;
					rem_n = rem_q - 8'd1;
					if (rem_q == 8'd1) phase_n = PH_TYPE;
				end
				default: ;
			endcase
		end
		if (pos_q != 12'd4095) pos_n = pos_q + 12'd1;
		work.dlen = tlen_n;
		cnt = {1'b0, pos_q} + 13'd1;
		if (cnt < 13'(HdrLen)) st = ST_SHORT;
		else if (!hgood_n) st = ferr_n;
		else if (cnt < 13'(HdrLen) + {2'b0, tlen_n}) st = ST_TRUNC;
		else if (!crcok_n) st = ST_NO_CRC;
		else if (~crc_n != scrc_n) st = ST_CRC_BAD;
		else if (ferr_n == ST_RESERVED) st = ST_RESERVED;
		else st = ST_OK;
		work.fin = last_byte;
		work.status = st;
		if (last_byte && cnt < 13'(HdrLen)) work.dlen = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; tlen_q <= '0; hgood_q <= 1'b1; phase_q <= PH_TYPE;
			ctype_q <= '0; rem_q <= '0; vcnt_q <= '0; crc_q <= '1;
			scrc_q <= '0; crcok_q <= 1'b0; ferr_q <= '0;
		end else if (in_go) begin
			if (last_byte) begin
				pos_q <= '0; tlen_q <= '0; hgood_q <= 1'b1; phase_q <= PH_TYPE;
				ctype_q <= '0; rem_q <= '0; vcnt_q <= '0; crc_q <= '1;
				scrc_q <= '0; crcok_q <= 1'b0; ferr_q <= '0;
			end else begin
				pos_q <= pos_n; tlen_q <= tlen_n; hgood_q <= hgood_n; phase_q <= phase_n;
				ctype_q <= ctype_n; rem_q <= rem_n; vcnt_q <= vcnt_n; crc_q <= crc_n;
				scrc_q <= scrc_n; crcok_q <= crcok_n; ferr_q <= ferr_n;
			end
		end
	end

endmodule

/* hw/rtl/tlvp_back.sv */
module tlvp_back import tlvp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  work_t   wdata,
	output logic    full,
	output logic    empty,
	input  logic    pop,
	output result_t res
);

	// queue of classified bytes; each entry expands to one or two results
	localparam int Depth = 4;
	work_t       mem_q [Depth];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        half_q;
	work_t       head;
	logic        two;
	logic        rd;
	logic        wr_en;

	assign head = mem_q[rp_q];
	assign two = head.emit && head.fin;
	assign empty = (cnt_q == 3'd0);
	assign full = (cnt_q == 3'(Depth));
	assign wr_en = wr && (wdata.emit || wdata.fin);
	assign rd = pop && !empty && (!two || half_q);

	always_comb begin
		res = '0;
		res.dlen = head.dlen;
		if (head.emit && !half_q) begin
			res.etype = head.etype;
			res.vidx = head.vidx;
			res.vbyte = head.vbyte;
			res.done = head.done;
			res.last = !head.fin;
		end else begin
			res.kind = 1'b1;
			res.status = head.status;
			res.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd};
			if (pop && !empty) half_q <= two && !half_q;
		end
	end

endmodule

/* hw/rtl/tlvp_checker.sv */
module tlvp_checker import tlvp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       kind,
	input logic [3:0] status,
	input logic [7:0] entry_type,
	input logic       last
);

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> last) else $error("status not last");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (status <= ST_TRUNC)) else $error("bad status");
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (entry_type == 8'd0)) else $error("status has type");
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind) |-> (status == ST_OK)) else $error("value has status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty) else $error("result lost");

endmodule

bind tlv_eeprom_record_parser_core tlvp_checker u_checker (
	.clk, .arst_n, .empty, .pop, .kind, .status, .entry_type, .last
);

/* tb/tb_tlv_eeprom_record_parser_core.sv */
module tb_tlv_eeprom_record_parser_core;
	import tlvp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 4000;

	// one decoded result as the block should present it
	typedef struct packed {
		logic        kind;
		logic [7:0]  etype;
		logic [7:0]  vidx;
		logic [7:0]  vbyte;
		logic        done;
		logic [3:0]  status;
		logic [10:0] dlen;
		logic        last;
	} rec_out_t;

	// one row of the directed part: byte, last flag, and an optional typed status and length
	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		logic        chk;
		logic [3:0]  st;
		logic [10:0] dl;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [7:0]  entry_type;
	logic [7:0]  value_index;
	logic [7:0]  value_out;
	logic        entry_done;
	logic [3:0]  status;
	logic [10:0] declared_length;
	logic        last;

	tlv_eeprom_record_parser_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
		.kind(kind), .entry_type(entry_type), .value_index(value_index),
		.value_out(value_out), .entry_done(entry_done), .status(status),
		.declared_length(declared_length), .last(last)
	);

	// shadow parse state
	logic [11:0] sh_pos;
	logic [10:0] sh_total;
	logic        sh_hdr_good;
	phase_t      sh_phase;
	logic [7:0]  sh_type;
	logic [7:0]  sh_remain;
	logic [7:0]  sh_count;
	logic [31:0] sh_crc;
	logic [31:0] sh_stored;
	logic        sh_crc_entry;
	logic [3:0]  sh_err;

	rec_out_t    want_q[$];
	logic [7:0]  rec_q[$];
	int          mismatches = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          stall_cnt = 0;

	// directed records: short, bad signature, length too large
	dir_row_t dir_tab[24] = '{
		'{8'h54, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h00, 1'b1, 1'b1, ST_SHORT, 11'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6C, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h76, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h49, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6E, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h66, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6F, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h00, 1'b1, 1'b1, ST_SIGNATURE, 11'd0},
		'{8'h54, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6C, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h76, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h49, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6E, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h66, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h6F, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 11'd0},
		'{8'hFF, 1'b1, 1'b1, ST_LENGTH, 11'd2047}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	// bytes emitted for an entry type; strings emit everything
	function automatic int emit_cap(input logic [7:0] t);
		if (t == TYPE_MAC) return 6;
		if (t == TYPE_COUNT) return 1;
		if (t == TYPE_VID) return 2;
		if (t == TYPE_CRC) return 4;
		if (t >= TYPE_STR_LO && t <= TYPE_STR_HI) return 255;
		return 0;
	endfunction

	function automatic logic [7:0] sig_char(input int p);
		case (p)
			0: return 8'h54;
			1: return 8'h6C;
			2: return 8'h76;
			3: return 8'h49;
			4: return 8'h6E;
			5: return 8'h66;
			6: return 8'h6F;
			default: return 8'h00;
		endcase
	endfunction

	task automatic clear_parse();
		sh_pos = '0;
		sh_total = '0;
		sh_hdr_good = 1'b1;
		sh_phase = PH_TYPE;
		sh_type = '0;
		sh_remain = '0;
		sh_count = '0;
		sh_crc = 32'hFFFFFFFF;
		sh_stored = '0;
		sh_crc_entry = 1'b0;
		sh_err = ST_OK;
	endtask

	task automatic header_bad(input logic [3:0] code);
		if (sh_hdr_good)
			sh_err = code;
		sh_hdr_good = 1'b0;
	endtask

	// work out the results that one accepted byte causes
	task automatic parse_byte(input logic [7:0] b, input logic lastb);
		int p;
		int fin_end;
		int span;
		int lim;
		int cnt;
		int full_len;
		rec_out_t r;
		p = sh_pos;
		if (p < HdrLen) begin
			sh_crc = crc_next(sh_crc, b);
			if (p < 8) begin
				if (b != sig_char(p))
					header_bad(ST_SIGNATURE);
			end else if (p == 8) begin
				if (b != 8'h01)
					header_bad(ST_VERSION);
			end else if (p == 9) begin
				sh_total = {3'd0, b};
			end else begin
				full_len = {sh_total[7:0], b};
				if (full_len > MaxRecord - HdrLen || full_len > 2047) begin
					header_bad(ST_LENGTH);
					sh_total = full_len > 2047 ? 11'd2047 : 11'(full_len);
				end else begin
					sh_total = 11'(full_len);
				end
			end
		end else if (sh_hdr_good) begin
			fin_end = HdrLen + sh_total;
			if (p < fin_end) begin
				if (p + 4 < fin_end)
					sh_crc = crc_next(sh_crc, b);
				else
					sh_stored = {sh_stored[23:0], b};
				// the crc entry must sit right in front of the stored crc
				if (sh_total >= 6) begin
					if (p == fin_end - 6)
						sh_crc_entry = (b == TYPE_CRC);
					if (p == fin_end - 5)
						sh_crc_entry = sh_crc_entry && (b == 8'd4);
				end
				case (sh_phase)
					PH_TYPE: begin
						if (b == TYPE_RSV_LO || b == TYPE_RSV_HI) begin
							if (sh_err == ST_OK)
								sh_err = ST_RESERVED;
							sh_phase = PH_HALT;
						end else begin
							sh_type = b;
							sh_phase = PH_LEN;
						end
					end
					PH_LEN: begin
						sh_remain = b;
						sh_count = '0;
						sh_phase = (b != 0) ? PH_VALUE : PH_TYPE;
					end
					PH_VALUE: begin
						span = sh_count + sh_remain;
						lim = emit_cap(sh_type);
						if (span < lim)
							lim = span;
						if (sh_count < lim) begin
							r = '0;
							r.etype = sh_type;
							r.vidx = sh_count;
							r.vbyte = b;
							r.done = (sh_count + 1 == lim);
							r.dlen = sh_total;
							r.last = !lastb;
							want_q.push_back(r);
						end
						sh_count = sh_count + 8'd1;
						sh_remain = sh_remain - 8'd1;
						if (sh_remain == 0)
							sh_phase = PH_TYPE;
					end
					default: begin
					end
				endcase
			end
		end
		if (sh_pos < 12'd4095)
			sh_pos = sh_pos + 12'd1;
		if (lastb) begin
			// status precedence: short, header, truncated, crc entry, crc, reserved
			cnt = p + 1;
			r = '0;
			r.kind = 1'b1;
			r.last = 1'b1;
			r.dlen = sh_total;
			if (cnt < HdrLen) begin
				r.status = ST_SHORT;
				r.dlen = '0;
			end else if (!sh_hdr_good)
				r.status = sh_err;
			else if (cnt < HdrLen + sh_total)
				r.status = ST_TRUNC;
			else if (!sh_crc_entry)
				r.status = ST_NO_CRC;
			else if ((sh_crc ^ 32'hFFFFFFFF) != sh_stored)
				r.status = ST_CRC_BAD;
			else if (sh_err == ST_RESERVED)
				r.status = ST_RESERVED;
			else
				r.status = ST_OK;
			want_q.push_back(r);
			clear_parse();
		end
	endtask

	// hand one byte over, with random idle cycles in front
	task automatic send_byte(input logic [7:0] b, input logic lastb);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= lastb;
		do
			@(posedge clk);
		while (full);
		parse_byte(b, lastb);
		@(negedge clk);
	endtask

	// well-formed record with random entries, then an occasional defect
	task automatic build_record();
		int n_ent;
		int len;
		int blen;
		int pos;
		logic [7:0] t;
		logic [31:0] c;
		rec_q.delete();
		for (int i = 0; i < 8; i++)
			rec_q.push_back(sig_char(i));
		rec_q.push_back(($urandom_range(14) == 0) ? 8'($urandom_range(255)) : 8'h01);
		rec_q.push_back(8'h00);
		rec_q.push_back(8'h00);
		n_ent = $urandom_range(4);
		for (int e = 0; e < n_ent; e++) begin
			case ($urandom_range(11))
				0: t = TYPE_MAC;
				1: t = TYPE_COUNT;
				2: t = TYPE_VID;
				3: t = TYPE_CRC;
				4: t = TYPE_VEND;
				5, 6: t = 8'($urandom_range(TYPE_STR_LO, TYPE_STR_HI));
				7: t = ($urandom_range(1) != 0) ? TYPE_RSV_LO : TYPE_RSV_HI;
				default: t = 8'($urandom_range(255));
			endcase
			len = ($urandom_range(5) == 0) ? $urandom_range(20) : $urandom_range(8);
			rec_q.push_back(t);
			rec_q.push_back(8'(len));
			for (int i = 0; i < len; i++)
				rec_q.push_back(8'($urandom_range(255)));
		end
		rec_q.push_back(TYPE_CRC);
		rec_q.push_back(8'd4);
		blen = rec_q.size() - HdrLen + 4;
		rec_q[9] = 8'(blen >> 8);
		rec_q[10] = 8'(blen);
		c = 32'hFFFFFFFF;
		foreach (rec_q[i])
			c = crc_next(c, rec_q[i]);
		c = c ^ 32'hFFFFFFFF;
		for (int i = 3; i >= 0; i--)
			rec_q.push_back(c[8 * i +: 8]);
		case ($urandom_range(9))
			0: begin
				pos = $urandom_range(rec_q.size() - 1);
				rec_q[pos] = rec_q[pos] ^ (8'd1 << $urandom_range(7));
			end
			1: begin
				pos = $urandom_range(1, rec_q.size() - 1);
				while (rec_q.size() > pos)
					void'(rec_q.pop_back());
			end
			2: begin
				repeat ($urandom_range(1, 3))
					rec_q.push_back(8'($urandom_range(255)));
			end
			3: begin
				rec_q[9] = 8'($urandom_range(255));
				rec_q[10] = 8'($urandom_range(255));
			end
			default: begin
			end
		endcase
	endtask

	// receiver stalls at random
	always @(negedge clk)
		pop <= ($urandom_range(99) >= recv_idle);

	// compare each popped result with the oldest prediction
	always @(posedge clk) begin
		rec_out_t w;
		if (arst_n && pop && !empty) begin
			if (want_q.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				mismatches++;
			end else begin
				w = want_q.pop_front();
				if (kind != w.kind) report("kind", kind, w.kind);
				if (entry_type != w.etype) report("entry_type", entry_type, w.etype);
				if (value_index != w.vidx) report("value_index", value_index, w.vidx);
				if (value_out != w.vbyte) report("value_out", value_out, w.vbyte);
				if (entry_done != w.done) report("entry_done", entry_done, w.done);
				if (status != w.status) report("status", status, w.status);
				if (declared_length != w.dlen)
					report("declared_length", declared_length, w.dlen);
				if (last != w.last) report("last", last, w.last);
			end
		end
	end

	// watchdog on cycles without any accepted push or pop
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int sent;
		int got_st;
		int got_dl;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		pop = 1'b0;
		clear_parse();
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows; typed status and length checked against the prediction too
		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].b, dir_tab[i].l);
			if (dir_tab[i].chk) begin
				got_st = want_q[$].status;
				got_dl = want_q[$].dlen;
				if (got_st != dir_tab[i].st) report("typed status", got_st, dir_tab[i].st);
				if (got_dl != dir_tab[i].dl) report("typed length", got_dl, dir_tab[i].dl);
			end
		end

		// random records in three idling phases
		sent = 0;
		while (sent < 850) begin
			if (sent < 280) begin
				send_idle = 32;
				recv_idle = 47;
			end else if (sent < 560) begin
				send_idle = 47;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			build_record();
			foreach (rec_q[i])
				send_byte(rec_q[i], i == rec_q.size() - 1);
			sent += rec_q.size();
		end
		push <= 1'b0;

		while (want_q.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tlvp_pkg.sv
hw/rtl/tlvp_front.sv
hw/rtl/tlvp_back.sv
hw/rtl/tlv_eeprom_record_parser_core.sv
hw/rtl/tlvp_checker.sv
tb/tb_tlv_eeprom_record_parser_core.sv
